FILE: rtl/geometric_latency_histogram_unit_assert.svh
// assertion macros for the top-level rtl, compiled out for synthesis
`ifndef GEOMETRIC_LATENCY_HISTOGRAM_UNIT_ASSERT_SVH
`define GEOMETRIC_LATENCY_HISTOGRAM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define GLH_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glh assertion failed");
`define GLH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glh assertion failed");
`else
`define GLH_ASSERT_IMPLY(label, ante, cons)
`define GLH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/glh_pkg.sv
`timescale 1ns / 1ps

package glh_pkg;

    localparam int LAT_W   = 48;
    localparam int FRAC_W  = 17;
    localparam int VALUE_W = 34;
    localparam int TOTAL_W = 40;

    localparam logic [FRAC_W-1:0] Q_ONE = 17'h10000;

    localparam logic OP_RECORD   = 1'b0;
    localparam logic OP_QUANTILE = 1'b1;

    typedef struct packed {
        logic active;
        logic found;
    } glh_tok_t;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_TGT  = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } glh_state_t;

    // bound table: start at 1, next = ceil(cur * 6 / 5), upper bound appended last
    function automatic longint unsigned glh_bound(int idx, longint unsigned ub, int nb);
        longint unsigned cur;
        longint unsigned res;
        int n;
        cur = 1;
        n   = 0;
        res = 0;
        while (cur < ub && n < nb - 1) begin
            if (n == idx)
                res = cur;
            cur = (cur * 6 + 4) / 5;
            n++;
        end
        if (n == idx)
            res = ub;
        return res;
    endfunction

    function automatic int glh_used(longint unsigned ub, int nb);
        longint unsigned cur;
        int n;
        cur = 1;
        n   = 0;
        while (cur < ub && n < nb - 1) begin
            cur = (cur * 6 + 4) / 5;
            n++;
        end
        return n + 1;
    endfunction

endpackage

FILE: rtl/glh_cell.sv
`timescale 1ns / 1ps

module glh_cell #(
    parameter int              COUNT_WIDTH = 40,
    parameter int              SUM_W       = 48,
    parameter longint unsigned BOUND       = 1,
    parameter bit              EN          = 1'b1,
    parameter bit              IS_LAST     = 1'b0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rec,
    input  logic [47:0]              lat,
    input  logic                     prev_gt,
    output logic                     gt,
    input  logic [COUNT_WIDTH-1:0]   target,
    input  glh_pkg::glh_tok_t        tok_in,
    input  logic [SUM_W-1:0]         sum_in,
    input  logic [33:0]              val_in,
    output glh_pkg::glh_tok_t        tok_out,
    output logic [SUM_W-1:0]         sum_out,
    output logic [33:0]              val_out
);
    import glh_pkg::*;

    localparam logic [LAT_W-1:0]       BOUND_CMP = BOUND[LAT_W-1:0];
    localparam logic [VALUE_W-1:0]     BOUND_VAL = BOUND[VALUE_W-1:0];
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    glh_tok_t               tok_reg;
    glh_tok_t               tok_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [VALUE_W-1:0]     val_reg;
    logic [VALUE_W-1:0]     val_next;
    logic                   hit_rec;
    logic                   hit_q;

    assign gt = EN && (lat > BOUND_CMP);

    // hit if above previous bound and, unless cell is last, not above this one
    assign hit_rec = rec && EN && ((prev_gt && !gt) || (IS_LAST && gt));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (hit_rec && cnt_reg != CNT_MAX)
            cnt_next = cnt_reg + 1'b1;
    end

    // running sum token moves one cell per cycle
    always_comb
    begin
        sum_next        = sum_in + SUM_W'(cnt_reg);
        hit_q           = tok_in.active && !tok_in.found && EN
                          && (sum_next >= SUM_W'(target));
        tok_next.active = tok_in.active;
        tok_next.found  = tok_in.found || hit_q;
        val_next        = hit_q ? BOUND_VAL : val_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            tok_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        val_reg <= val_next;
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;
    assign val_out = val_reg;

endmodule

FILE: rtl/geometric_latency_histogram_unit.sv
`timescale 1ns / 1ps

// Latency histogram over geometric buckets (bounds 1, then ceil(x*1.2), up to
// UPPER_BOUND), held as a row of NUM_BUCKETS cells, one count per cell. A record
// request is folded in on the cycle it is taken; its result passes through S_DONE
// into the output register. A quantile request multiplies the total by the
// fraction (S_MUL, S_TGT) and then passes a running-sum token through the cell
// row, one cell a cycle; on an empty histogram it skips both and returns zero.
// One request is worked on at a time; a finished result sits in the output
// register while the next request is taken.
module geometric_latency_histogram_unit #(
    parameter int              NUM_BUCKETS = 128,
    parameter longint unsigned UPPER_BOUND = 64'd10000000000,
    parameter int              COUNT_WIDTH = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [47:0] latency_us,
    input  logic [16:0] quantile_frac,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [33:0] quantile_value,
    output logic [39:0] sample_total,
    output logic [47:0] max_latency
);
    import glh_pkg::*;

    `include "geometric_latency_histogram_unit_assert.svh"

    localparam int              USED   = glh_used(UPPER_BOUND, NUM_BUCKETS);
    localparam longint unsigned LASTB  = glh_bound(USED - 1, UPPER_BOUND, NUM_BUCKETS);
    localparam logic [VALUE_W-1:0] LAST_VAL = LASTB[VALUE_W-1:0];
    localparam int SUM_W  = COUNT_WIDTH + 8;
    localparam int PROD_W = COUNT_WIDTH + FRAC_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    glh_state_t             state_reg;
    glh_state_t             state_next;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [COUNT_WIDTH-1:0] total_next;
    logic [LAT_W-1:0]       max_reg;
    logic [LAT_W-1:0]       max_next;
    logic [FRAC_W-1:0]      q_reg;
    logic [FRAC_W-1:0]      q_next;
    logic [PROD_W-1:0]      prod_reg;
    logic [PROD_W:0]        prod_round;
    logic [COUNT_WIDTH-1:0] target;
    logic [VALUE_W-1:0]     res_reg;
    logic [VALUE_W-1:0]     res_next;
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     out_q_reg;
    logic [COUNT_WIDTH-1:0] out_tot_reg;
    logic [LAT_W-1:0]       out_max_reg;
    logic [63:0]            tot_wide;
    logic                   accept;
    logic                   rec;
    logic                   start;
    logic                   load_out;

    glh_tok_t               tok_w [NUM_BUCKETS+1];
    logic [SUM_W-1:0]       sum_w [NUM_BUCKETS+1];
    logic [VALUE_W-1:0]     val_w [NUM_BUCKETS+1];
    logic                   gt_w  [NUM_BUCKETS+1];

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign rec      = accept && (opcode == OP_RECORD);
    assign start    = (state_reg == S_TGT);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign tok_w[0].active = start;
    assign tok_w[0].found  = 1'b0;
    assign sum_w[0]        = '0;
    assign val_w[0]        = '0;
    assign gt_w[0]         = 1'b1;

    for (genvar i = 0; i < NUM_BUCKETS; i++)
    begin : g_cell
        glh_cell #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .SUM_W       (SUM_W),
            .BOUND       (glh_bound(i, UPPER_BOUND, NUM_BUCKETS)),
            .EN          (i < USED),
            .IS_LAST     (i == USED - 1)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .rec     (rec),
            .lat     (latency_us),
            .prev_gt (gt_w[i]),
            .gt      (gt_w[i+1]),
            .target  (target),
            .tok_in  (tok_w[i]),
            .sum_in  (sum_w[i]),
            .val_in  (val_w[i]),
            .tok_out (tok_w[i+1]),
            .sum_out (sum_w[i+1]),
            .val_out (val_w[i+1])
        );
    end

    // ceil(total * q / 2^16), held steady by prod_reg from the token start on
    assign prod_round = {1'b0, prod_reg} + (PROD_W + 1)'(16'hFFFF);
    assign target     = prod_round[COUNT_WIDTH+15:16];

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        max_next   = max_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_RECORD)
                    begin
                        if (total_reg != CNT_MAX)
                            total_next = total_reg + 1'b1;
                        if (latency_us > max_reg)
                            max_next = latency_us;
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else if (total_reg == '0)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        q_next     = (quantile_frac > Q_ONE) ? Q_ONE : quantile_frac;
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
                state_next = S_TGT;
            S_TGT:
                state_next = S_WALK;
            S_WALK:
            begin
                if (tok_w[NUM_BUCKETS].active)
                begin
                    res_next   = tok_w[NUM_BUCKETS].found ? val_w[NUM_BUCKETS] : LAST_VAL;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            max_reg   <= max_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        res_reg    <= res_next;
        prod_reg   <= PROD_W'(total_reg) * PROD_W'(q_reg);
        if (load_out)
        begin
            out_q_reg   <= res_reg;
            out_tot_reg <= total_reg;
            out_max_reg <= max_reg;
        end
    end

    assign tot_wide       = 64'(out_tot_reg);
    assign out_valid      = out_valid_reg;
    assign quantile_value = out_q_reg;
    assign sample_total   = tot_wide[TOTAL_W-1:0];
    assign max_latency    = out_max_reg;

    `GLH_ASSERT_NEXT(a_walk_ends, (state_reg == S_WALK) && tok_w[NUM_BUCKETS].active, state_reg == S_DONE)
    `GLH_ASSERT_NEXT(a_rec_max, rec, max_reg >= $past(latency_us))
    `GLH_ASSERT_NEXT(a_rec_total, rec, (total_reg == CNT_MAX) || (total_reg == $past(total_reg) + 1'b1))
    `GLH_ASSERT_IMPLY(a_load_done, load_out, state_reg == S_DONE)

endmodule
